/* design/sli_pkg.sv */
`timescale 1ns / 1ps

package sli_pkg;

    // Operation codes on the input channel
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DELETED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    // Fixed field widths
    localparam int VALUE_W  = 8;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;

    // Flags from the shared compare unit
    typedef struct packed {
        logic ge;   // stored entry >= probe value (signed)
        logic eq;   // stored entry == probe value
    } cmp_flags_t;

endpackage

/* design/sli_ram.sv */
`timescale 1ns / 1ps

module sli_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/sli_cmp.sv */
`timescale 1ns / 1ps

module sli_cmp (
    input  logic signed [sli_pkg::VALUE_W-1:0] entry,
    input  logic signed [sli_pkg::VALUE_W-1:0] probe,
    output sli_pkg::cmp_flags_t                flags
);

    // Compare one stored entry against the probe value as signed bytes
    always_comb begin
        flags.ge = (entry >= probe);
        flags.eq = (entry == probe);
    end

endmodule

/* design/sorted_list_insert_delete_core.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// s_       in         s_valid / s_ready    s_op, s_value
// m_       out        m_valid / m_ready    m_status, m_position, m_entry_count,
//                                          m_smallest_value
//
// An insert scans down from the tail until its slot is found, a delete scans
// the whole list up from the head, and a full or empty case goes straight to
// the done state; each result is then loaded into the result register. The list
// lives in a one-write one-read RAM with registered read data, so every entry
// visited passes through a read state and a compare/write state.
// Reset clears the count, the sequencer and the result valid; the RAM holds
// no meaning until written and needs no clearing pass.
// While m_ready is low the result holds; the next transfer is still taken and
// its result waits in the sequencer until the result register frees up.

module sorted_list_insert_delete_core #(
    parameter int CAPACITY = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_op,
    input  logic signed [sli_pkg::VALUE_W-1:0]    s_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [sli_pkg::STATUS_W-1:0]          m_status,
    output logic [sli_pkg::POS_W-1:0]             m_position,
    output logic [sli_pkg::COUNT_W-1:0]           m_entry_count,
    output logic signed [sli_pkg::VALUE_W-1:0]    m_smallest_value
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = sli_pkg::VALUE_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_DEL_RD  = 3'd3;
    localparam logic [2:0] S_DEL_CMP = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]                   state_reg,  state_next;
    logic [CW-1:0]                k_reg,      k_next;
    logic [CW-1:0]                count_reg,  count_next;
    logic                         found_reg,  found_next;
    logic signed [VW-1:0]         value_reg,  value_next;
    logic signed [VW-1:0]         head_reg,   head_next;
    logic [sli_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [AW-1:0]                pos_reg,    pos_next;

    logic                         m_valid_reg,    m_valid_next;
    logic [sli_pkg::STATUS_W-1:0] m_status_reg,   m_status_next;
    logic [sli_pkg::POS_W-1:0]    m_position_reg, m_position_next;
    logic [sli_pkg::COUNT_W-1:0]  m_count_reg,    m_count_next;
    logic signed [VW-1:0]         m_smallest_reg, m_smallest_next;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [VW-1:0]                wr_data;
    logic [AW-1:0]                rd_addr;
    logic [VW-1:0]                rd_data;
    sli_pkg::cmp_flags_t          flags;

    logic [CW-1:0]                k_dec;
    logic [CW-1:0]                k_inc;
    logic                         load_out;

    assign k_dec = k_reg - CW'(1);
    assign k_inc = k_reg + CW'(1);

    // List storage
    sli_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared compare unit
    sli_cmp u_cmp (
        .entry (rd_data),
        .probe (value_reg),
        .flags (flags)
    );

    // Insert scans down from the top entry, delete scans up from the head
    assign rd_addr = (state_reg == S_INS_RD) ? k_dec[AW-1:0] : k_reg[AW-1:0];

    assign s_ready  = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        k_next      = k_reg;
        count_next  = count_reg;
        found_next  = found_reg;
        value_next  = value_reg;
        head_next   = head_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        wr_en       = 1'b0;
        wr_addr     = k_reg[AW-1:0];
        wr_data     = value_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    value_next = s_value;
                    found_next = 1'b0;
                    pos_next   = '0;
                    if (s_op == sli_pkg::OP_INSERT) begin
                        if (count_reg >= CW'(CAPACITY)) begin
                            status_next = sli_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end else begin
                            k_next     = count_reg;
                            state_next = S_INS_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = sli_pkg::ST_EMPTY;
                            state_next  = S_DONE;
                        end else begin
                            k_next     = '0;
                            state_next = S_DEL_RD;
                        end
                    end
                end
            end

            S_INS_RD: begin
                // Reached the head: the new value becomes the smallest
                if (k_reg == '0) begin
                    wr_en       = 1'b1;
                    wr_addr     = '0;
                    wr_data     = value_reg;
                    head_next   = value_reg;
                    pos_next    = '0;
                    count_next  = count_reg + CW'(1);
                    status_next = sli_pkg::ST_INSERTED;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP: begin
                wr_en   = 1'b1;
                wr_addr = k_reg[AW-1:0];
                if (flags.ge) begin
                    // Shift the entry up one slot and keep scanning
                    wr_data    = rd_data;
                    k_next     = k_dec;
                    state_next = S_INS_RD;
                end else begin
                    wr_data     = value_reg;
                    pos_next    = k_reg[AW-1:0];
                    count_next  = count_reg + CW'(1);
                    status_next = sli_pkg::ST_INSERTED;
                    state_next  = S_DONE;
                end
            end

            S_DEL_RD: begin
                state_next = S_DEL_CMP;
            end

            S_DEL_CMP: begin
                // Behind the match, pull each entry down one slot
                if (found_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = k_dec[AW-1:0];
                    wr_data = rd_data;
                    if (k_reg == CW'(1)) begin
                        head_next = rd_data;
                    end
                end else if (flags.eq) begin
                    found_next = 1'b1;
                    pos_next   = k_reg[AW-1:0];
                end
                k_next = k_inc;
                if (k_inc == count_reg) begin
                    if (found_reg || flags.eq) begin
                        count_next  = count_reg - CW'(1);
                        status_next = sli_pkg::ST_DELETED;
                    end else begin
                        status_next = sli_pkg::ST_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end else begin
                    state_next = S_DEL_RD;
                end
            end

            S_DONE: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_position_next = m_position_reg;
        m_count_next    = m_count_reg;
        m_smallest_next = m_smallest_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next    = 1'b1;
            m_status_next   = status_reg;
            m_position_next = sli_pkg::POS_W'(pos_reg);
            m_count_next    = sli_pkg::COUNT_W'(count_reg);
            m_smallest_next = (count_reg != '0) ? head_reg : '0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            k_reg       <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        value_reg      <= value_next;
        head_reg       <= head_next;
        status_reg     <= status_next;
        pos_reg        <= pos_next;
        m_status_reg   <= m_status_next;
        m_position_reg <= m_position_next;
        m_count_reg    <= m_count_next;
        m_smallest_reg <= m_smallest_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_position       = m_position_reg;
    assign m_entry_count    = m_count_reg;
    assign m_smallest_value = m_smallest_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_ins_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_CMP) |-> (k_reg != '0) && (k_reg <= count_reg))
        else $error("insert scan index out of range");

    a_del_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DEL_CMP) |-> (k_reg < count_reg))
        else $error("delete scan index out of range");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && status_reg == sli_pkg::ST_FULL)
            |-> (count_reg == CW'(CAPACITY)))
        else $error("full reported below capacity");

    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !wr_en)
        else $error("list write outside a scan");

endmodule

/* dv/sorted_list_insert_delete_core_tb.sv */
`timescale 1ns / 1ps

module sorted_list_insert_delete_core_tb;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 550;
    localparam int TAIL_CYCLES  = 100;
    localparam int HOLD_START   = 400;
    localparam int HOLD_CYCLES  = 300;

    // Two copies of the list: one tracks accepted transfers, one steers the generator
    localparam int LIST_ACCEPTED  = 0;
    localparam int LIST_GENERATOR = 1;

    typedef struct packed {
        logic                               op;
        logic signed [sli_pkg::VALUE_W-1:0] value;
    } list_cmd_t;

    typedef struct packed {
        logic [sli_pkg::STATUS_W-1:0]       status;
        logic [sli_pkg::POS_W-1:0]          position;
        logic [sli_pkg::COUNT_W-1:0]        entry_count;
        logic signed [sli_pkg::VALUE_W-1:0] smallest;
    } list_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_op = sli_pkg::OP_INSERT;
    logic signed [sli_pkg::VALUE_W-1:0] s_value = '0;
    logic m_ready = 1'b0;
    logic s_ready;
    logic m_valid;
    logic [sli_pkg::STATUS_W-1:0] m_status;
    logic [sli_pkg::POS_W-1:0] m_position;
    logic [sli_pkg::COUNT_W-1:0] m_entry_count;
    logic signed [sli_pkg::VALUE_W-1:0] m_smallest_value;

    logic signed [sli_pkg::VALUE_W-1:0] list_entries [2][CAPACITY];
    int list_count [2];

    list_cmd_t pending_cmds [$];
    list_result_t expected_results [$];
    list_result_t want;
    list_result_t got;

    int items_sent = 0;
    int hold_cycles = 0;
    int error_count = 0;
    int tx_idle_pct;
    int rx_idle_pct;
    logic hold_active;

    sorted_list_insert_delete_core #(
        .CAPACITY(CAPACITY)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_position(m_position),
        .m_entry_count(m_entry_count),
        .m_smallest_value(m_smallest_value)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Apply one operation to a list copy and return the result it produces
    function automatic list_result_t apply_list_op(input int which, input logic op,
                                                   input logic signed [sli_pkg::VALUE_W-1:0] v);
        list_result_t r;
        int n;
        int i;
        n = list_count[which];
        r.position = '0;
        i = 0;
        if (op == sli_pkg::OP_INSERT) begin
            if (n >= CAPACITY) begin
                r.status = sli_pkg::ST_FULL;
            end else begin
                while (i < n && v > list_entries[which][i]) i++;
                for (int k = n; k > i; k--) list_entries[which][k] = list_entries[which][k-1];
                list_entries[which][i] = v;
                list_count[which] = n + 1;
                r.status = sli_pkg::ST_INSERTED;
                r.position = i[sli_pkg::POS_W-1:0];
            end
        end else if (n == 0) begin
            r.status = sli_pkg::ST_EMPTY;
        end else begin
            while (i < n && list_entries[which][i] != v) i++;
            if (i >= n) begin
                r.status = sli_pkg::ST_NOT_FOUND;
            end else begin
                for (int k = i; k < n - 1; k++) list_entries[which][k] = list_entries[which][k+1];
                list_count[which] = n - 1;
                r.status = sli_pkg::ST_DELETED;
                r.position = i[sli_pkg::POS_W-1:0];
            end
        end
        r.entry_count = list_count[which][sli_pkg::COUNT_W-1:0];
        r.smallest = (list_count[which] > 0) ? list_entries[which][0] : '0;
        return r;
    endfunction

    // Queue one command and track it in the generator's copy of the list
    task automatic queue_cmd(input logic op, input logic signed [sli_pkg::VALUE_W-1:0] v);
        list_cmd_t c;
        c.op = op;
        c.value = v;
        pending_cmds.push_back(c);
        void'(apply_list_op(LIST_GENERATOR, op, v));
    endtask

    task automatic report_mismatch(input string what, input int got_val, input int want_val);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got_val, want_val, $realtime);
        error_count++;
    endtask

    // Idle rates per traffic phase: sender light then heavy, then no idling
    always @* begin
        if (items_sent < 190) begin
            tx_idle_pct = 27;
            rx_idle_pct = 81;
        end else if (items_sent < 380) begin
            tx_idle_pct = 81;
            rx_idle_pct = 27;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    assign hold_active = (items_sent >= HOLD_START) && (hold_cycles < HOLD_CYCLES);

    // Count the long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cycles <= 0;
        end else if (hold_active) begin
            hold_cycles <= hold_cycles + 1;
        end
    end

    // Drive the input channel; predict each accepted transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(apply_list_op(LIST_ACCEPTED, s_op, s_value));
                items_sent <= items_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    s_valid <= 1'b1;
                    s_op <= pending_cmds[0].op;
                    s_value <= pending_cmds[0].value;
                    pending_cmds.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_status, m_position, m_entry_count, m_smallest_value};
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected, status", m_status, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.position !== want.position)
                        report_mismatch("position", got.position, want.position);
                    if (got.entry_count !== want.entry_count)
                        report_mismatch("entry_count", got.entry_count, want.entry_count);
                    if (got.smallest !== want.smallest)
                        report_mismatch("smallest_value", got.smallest, want.smallest);
                end
            end
            m_ready <= !hold_active && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int mode;
        int burst;
        int insert_pct;
        int n_gen;
        logic op;
        logic signed [sli_pkg::VALUE_W-1:0] v;

        list_count[LIST_ACCEPTED] = 0;
        list_count[LIST_GENERATOR] = 0;

        // Directed: empty delete, extremes, duplicates, zero, head and tail removal
        queue_cmd(sli_pkg::OP_DELETE, 8'sd0);
        queue_cmd(sli_pkg::OP_INSERT, 8'sd127);
        queue_cmd(sli_pkg::OP_INSERT, -8'sd128);
        queue_cmd(sli_pkg::OP_INSERT, 8'sd0);
        queue_cmd(sli_pkg::OP_INSERT, 8'sd0);
        queue_cmd(sli_pkg::OP_INSERT, -8'sd1);
        queue_cmd(sli_pkg::OP_INSERT, 8'sd1);
        queue_cmd(sli_pkg::OP_DELETE, 8'sd5);
        queue_cmd(sli_pkg::OP_DELETE, 8'sd0);
        queue_cmd(sli_pkg::OP_DELETE, -8'sd128);
        queue_cmd(sli_pkg::OP_DELETE, 8'sd127);
        queue_cmd(sli_pkg::OP_DELETE, 8'sd0);
        queue_cmd(sli_pkg::OP_DELETE, -8'sd1);
        queue_cmd(sli_pkg::OP_DELETE, 8'sd1);
        queue_cmd(sli_pkg::OP_DELETE, 8'sd1);
        queue_cmd(sli_pkg::OP_INSERT, 8'sh55);
        queue_cmd(sli_pkg::OP_INSERT, -8'sd86);
        queue_cmd(sli_pkg::OP_DELETE, 8'sh55);
        queue_cmd(sli_pkg::OP_DELETE, -8'sd86);

        // Random bursts: fill past full, drain past empty, or mix
        n_gen = 0;
        while (n_gen < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 2);
            burst = $urandom_range(10, 40);
            insert_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            for (int b = 0; b < burst; b++) begin
                op = ($urandom_range(0, 99) < insert_pct) ? sli_pkg::OP_INSERT
                                                          : sli_pkg::OP_DELETE;
                if (op == sli_pkg::OP_DELETE && list_count[LIST_GENERATOR] > 0
                        && $urandom_range(0, 99) < 75) begin
                    v = list_entries[LIST_GENERATOR]
                        [$urandom_range(0, list_count[LIST_GENERATOR] - 1)];
                end else if ($urandom_range(0, 99) < 40) begin
                    case ($urandom_range(0, 6))
                        0: v = -8'sd128;
                        1: v = 8'sd127;
                        2: v = -8'sd1;
                        3: v = 8'sd1;
                        default: v = 8'sd0;
                    endcase
                end else begin
                    v = sli_pkg::VALUE_W'($urandom_range(0, 255));
                end
                queue_cmd(op, v);
                n_gen++;
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain stimulus, then expectations, then let the block settle
        while (pending_cmds.size() > 0 || s_valid) @(posedge aclk);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
design/sli_pkg.sv
design/sli_ram.sv
design/sli_cmp.sv
design/sorted_list_insert_delete_core.sv
dv/sorted_list_insert_delete_core_tb.sv
